[rtl/uvt_pkg.sv]
package uvt_pkg;

    typedef enum logic [2:0] {
        FUNC_INSERT  = 3'd0,
        FUNC_FIND    = 3'd1,
        FUNC_DELETE  = 3'd2,
        FUNC_REPLACE = 3'd3,
        FUNC_LIST    = 3'd4,
        FUNC_SORTED  = 3'd5,
        FUNC_STATS   = 3'd6,
        FUNC_NONE    = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SORT,
        S_EMIT,
        S_DIV,
        S_RESULT
    } state_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic        write;     // write cell at index wsel with wdata
        logic        repl;      // replace all live matches of key with wdata
        logic        load;      // copy stored values into the working row
        logic        shift;     // rotate the working row one step towards cell 0
        logic        sort;      // odd-even transposition step on the working row
        logic        odd;       // phase of the sort step
        logic [31:0] key;
        logic [31:0] wdata;
    } cell_cmd_t;

    localparam int SUM_W  = 37;
    localparam int MEAN_W = 40;
    // Sum with 8 fraction bits appended
    localparam int DIVD_W = SUM_W + 8;

endpackage

[rtl/uvt_cell.sv]
module uvt_cell
#(
    parameter int IDX_W = 5,
    parameter logic [IDX_W-1:0] INDEX = '0
)
(
    input  logic                       clk,
    input  uvt_pkg::cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]           wsel,
    input  logic                       live,
    input  logic signed [31:0]         from_next,
    input  logic signed [31:0]         from_prev,
    input  logic                       has_next,
    output logic signed [31:0]         data,
    output logic signed [31:0]         aux,
    output logic                       match
);
    import uvt_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic signed [31:0] aux_reg;
    logic signed [31:0] aux_next;
    logic               lower_side;

    assign data  = data_reg;
    assign aux   = aux_reg;
    assign match = live && (data_reg == cmd.key);
    // In an odd-phase step pairs start at odd indices, else at even ones.
    assign lower_side = (INDEX[0] == cmd.odd);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.write && (wsel == INDEX))
            data_next = cmd.wdata;
        else if (cmd.repl && match)
            data_next = cmd.wdata;
    end

    // Working copy: listing, sorting and the stats walk never disturb stored order.
    always_comb
    begin
        aux_next = aux_reg;
        if (cmd.load)
            aux_next = data_reg;
        else if (cmd.shift)
            aux_next = from_next;
        else if (cmd.sort && live)
        begin
            if (lower_side)
            begin
                if (has_next && from_next < aux_reg)
                    aux_next = from_next;
            end
            else if (INDEX != '0 && from_prev > aux_reg)
                aux_next = from_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        aux_reg  <= aux_next;
    end

endmodule

[rtl/uvt_div.sv]
module uvt_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [uvt_pkg::DIVD_W-1:0]   dividend,
    input  logic [6:0]                          divisor,
    output logic                                done,
    output logic signed [uvt_pkg::MEAN_W-1:0]   quotient
);
    import uvt_pkg::*;

    logic [DIVD_W-1:0] q_reg, q_next;
    logic [7:0]        r_reg, r_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              neg_reg, neg_next;
    logic [7:0]        trial;
    logic [DIVD_W-1:0] mag;

    assign mag   = dividend[DIVD_W-1] ? DIVD_W'(-dividend) : dividend;
    assign trial = {r_reg[6:0], q_reg[DIVD_W-1]};
    assign done  = busy_reg && (cnt_reg == 6'd0);
    // Quotient magnitude always fits the mean width
    assign quotient = neg_reg ? MEAN_W'(-q_reg) : MEAN_W'(q_reg);

    // Restoring divide, one quotient bit per cycle.
    always_comb
    begin
        q_next = q_reg; r_next = r_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; neg_next = neg_reg;
        if (start)
        begin
            q_next = mag; r_next = '0; cnt_next = 6'(DIVD_W);
            busy_next = 1'b1; neg_next = dividend[DIVD_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
                busy_next = 1'b0;
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                if (trial >= {1'b0, divisor})
                begin
                    r_next = trial - {1'b0, divisor};
                    q_next = {q_reg[DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = trial;
                    q_next = {q_reg[DIVD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; neg_reg <= neg_next;
    end

endmodule

[rtl/unsorted_value_table_engine.sv]
// Insert, find, delete, replace: applied in the scan state; out_valid is registered from the result state.
// List: first result is registered from the emit state, then one per cycle while out_ready is high.
// Sorted list: as list, with DEPTH odd-even sort steps before the first result.
// Stats: a walk of the row through all DEPTH cells, then the divider, then the result.
// One transaction at a time; the next input is taken as the last result leaves.
// rst_n clears control and count only.
module unsorted_value_table_engine
#(
    parameter int DEPTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          func,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  new_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [4:0]          position,
    output logic signed [31:0]  item_value,
    output logic signed [36:0]  total,
    output logic signed [31:0]  smallest,
    output logic signed [31:0]  largest,
    output logic signed [39:0]  mean,
    output logic [5:0]          count,
    output logic [5:0]          replaced,
    output logic                last
);
    import uvt_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t             state_reg, state_next;
    func_t              func_reg;
    logic signed [31:0] value_reg, nv_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [31:0] min_reg, min_next, max_reg, max_next;

    logic               ov_reg, ov_next;
    logic [1:0]         o_status_reg, o_status_next;
    logic [4:0]         o_pos_reg, o_pos_next;
    logic signed [31:0] o_item_reg, o_item_next;
    logic               o_last_reg, o_last_next;
    logic [5:0]         o_repl_reg, o_repl_next;

    cell_cmd_t          cmd;
    logic [IDX_W-1:0]   wsel;
    logic signed [31:0] cdata [DEPTH];
    logic signed [31:0] caux [DEPTH];
    logic [DEPTH-1:0]   cmatch;
    logic [DEPTH-1:0]   clive;

    logic               div_start, div_done;
    logic signed [MEAN_W-1:0] div_q;

    logic               found;
    logic [IDX_W-1:0]   first_idx;
    logic [CNT_W-1:0]   nmatch;
    logic               accept;
    logic               out_free;

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign clive[g] = (CNT_W'(g) < n_reg);
            uvt_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(g))) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .wsel      (wsel),
                .live      (clive[g]),
                .from_next (caux[(g + 1) % DEPTH]),
                .from_prev (caux[(g + DEPTH - 1) % DEPTH]),
                .has_next  ((g + 1 < DEPTH) && clive[(g + 1) % DEPTH]),
                .data      (cdata[g]),
                .aux       (caux[g]),
                .match     (cmatch[g])
            );
        end
    endgenerate

    // Priority pick of the first match and a count of matches.
    always_comb
    begin
        found = 1'b0; first_idx = '0; nmatch = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cmatch[i])
            begin
                found = 1'b1; first_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < DEPTH; i++)
            nmatch = nmatch + CNT_W'(cmatch[i]);
    end

    // Dividend taken from sum_next so the last entry of a full table is counted.
    uvt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_next, 8'd0}),
        .divisor  (7'(n_reg)),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && func_t'(func) != FUNC_NONE)
                    state_next = S_SCAN;
            S_SCAN:
                unique case (func_reg)
                    FUNC_LIST:
                        state_next = (n_reg == '0) ? S_RESULT : S_EMIT;
                    FUNC_SORTED:
                        state_next = (n_reg == '0) ? S_RESULT : S_SORT;
                    FUNC_STATS:
                        state_next = (n_reg == '0) ? S_RESULT : S_DIV;
                    default:
                        state_next = S_RESULT;
                endcase
            S_SORT:
                if (step_reg == CNT_W'(DEPTH - 1))
                    state_next = S_EMIT;
            S_EMIT:
                if (out_free && emit_reg == n_reg - CNT_W'(1))
                    state_next = S_IDLE;
            S_DIV:
                if (div_done)
                    state_next = S_RESULT;
            S_RESULT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Cell commands and datapath updates.
    always_comb
    begin
        cmd = '0;
        cmd.key = value_reg;
        cmd.odd = step_reg[0];
        wsel = '0;
        n_next = n_reg; step_next = step_reg; emit_next = emit_reg;
        sum_next = sum_reg; min_next = min_reg; max_next = max_reg;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0; emit_next = '0;
            end
            S_SCAN:
            begin
                cmd.load = 1'b1;
                sum_next = '0;
                min_next = cdata[0]; max_next = cdata[0];
                unique case (func_reg)
                    FUNC_INSERT:
                        if (n_reg < CNT_W'(DEPTH))
                        begin
                            cmd.write = 1'b1; wsel = IDX_W'(n_reg);
                            cmd.wdata = value_reg; n_next = n_reg + CNT_W'(1);
                        end
                    FUNC_DELETE:
                        if (found)
                        begin
                            cmd.write = 1'b1; wsel = first_idx;
                            cmd.wdata = cdata[IDX_W'(n_reg - CNT_W'(1))];
                            n_next = n_reg - CNT_W'(1);
                        end
                    FUNC_REPLACE:
                    begin
                        cmd.repl = 1'b1; cmd.wdata = nv_reg;
                    end
                    default: ;
                endcase
            end
            S_SORT:
            begin
                cmd.sort = 1'b1; step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(DEPTH - 1))
                    step_next = '0;
            end
            S_EMIT:
                // Working cell 0 is shown, then the row moves on.
                if (out_free)
                begin
                    cmd.shift = 1'b1;
                    emit_next = emit_reg + CNT_W'(1);
                end
            S_DIV:
            begin
                if (step_reg < CNT_W'(DEPTH))
                begin
                    cmd.shift = 1'b1;
                    step_next = step_reg + CNT_W'(1);
                    if (step_reg < n_reg)
                    begin
                        sum_next = sum_reg + SUM_W'(caux[0]);
                        if (caux[0] < min_reg) min_next = caux[0];
                        if (caux[0] > max_reg) max_next = caux[0];
                    end
                    if (step_reg == CNT_W'(DEPTH - 1))
                        div_start = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_comb
    begin
        ov_next = ov_reg && !out_ready;
        o_status_next = o_status_reg; o_pos_next = o_pos_reg;
        o_item_next = o_item_reg; o_last_next = o_last_reg;
        o_repl_next = o_repl_reg;
        if (state_reg == S_SCAN)
        begin
            o_pos_next = '0; o_repl_next = '0; o_item_next = '0;
            o_last_next = 1'b1; o_status_next = ST_OK;
            unique case (func_reg)
                FUNC_INSERT:
                    if (n_reg >= CNT_W'(DEPTH)) o_status_next = ST_FULL;
                FUNC_FIND:
                    if (found) o_pos_next = 5'(first_idx);
                    else o_status_next = ST_NOT_FOUND;
                FUNC_DELETE:
                    if (!found) o_status_next = ST_NOT_FOUND;
                FUNC_REPLACE:
                begin
                    o_repl_next = 6'(nmatch);
                    if (nmatch == '0) o_status_next = ST_NOT_FOUND;
                end
                default:
                    if (n_reg == '0) o_status_next = ST_EMPTY;
            endcase
        end
        if (state_reg == S_RESULT && out_free)
            ov_next = 1'b1;
        if (state_reg == S_EMIT && out_free && emit_reg < n_reg)
        begin
            ov_next = 1'b1;
            o_item_next = caux[0];
            o_last_next = (emit_reg == n_reg - CNT_W'(1));
            o_status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; n_reg <= '0; ov_reg <= 1'b0;
            step_reg <= '0; emit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; n_reg <= n_next;
            step_reg <= step_next; emit_reg <= emit_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func); value_reg <= value; nv_reg <= new_value;
        end
        sum_reg <= sum_next; min_reg <= min_next; max_reg <= max_next;
        o_status_reg <= o_status_next; o_pos_reg <= o_pos_next;
        o_item_reg <= o_item_next; o_last_reg <= o_last_next;
        o_repl_reg <= o_repl_next;
    end

    // Stats fields only shown for a stats transaction on a non-empty table.
    logic show_stats;
    assign show_stats = (func_reg == FUNC_STATS) && (o_status_reg == ST_OK) && !o_pos_reg[0]
                        && ov_reg;

    logic signed [MEAN_W-1:0] mean_reg;
    always_ff @(posedge clk)
        if (div_done)
            mean_reg <= div_q;

    assign out_valid  = ov_reg;
    assign status     = o_status_reg;
    assign position   = o_pos_reg;
    assign item_value = o_item_reg;
    assign total      = show_stats ? sum_reg : '0;
    assign smallest   = show_stats ? min_reg : '0;
    assign largest    = show_stats ? max_reg : '0;
    assign mean       = show_stats ? mean_reg : '0;
    assign count      = 6'(n_reg);
    assign replaced   = o_repl_reg;
    assign last       = o_last_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_SCAN |=> n_reg == $past(n_reg))
        else $error("count changed outside scan");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_value))
        else $error("result dropped");

endmodule
